>>> hw/rtl/lpht_pkg.sv
package lpht_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CAP_W       = $clog2(TABLE_DEPTH + 1);
	localparam int REM_W       = SLOT_W + 1;
	localparam int CFG_W       = 9;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 16;
	localparam int MODE_W      = 2;
	localparam int STAT_W      = 2;

	// remainder unit: key bits retired per cycle
	localparam int DIV_BITS    = 4;
	localparam int DIV_CYCLES  = KEY_W / DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

	localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_MISS     = 2'd1,
		ST_FULL     = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] dividend;
		logic [CAP_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] rem;
	} div_rsp_t;

endpackage

>>> hw/rtl/lpht_ram.sv
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/lpht_mod.sv
module lpht_mod
	import lpht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	// restoring remainder, DIV_BITS dividend bits per cycle, MSB first
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0]     dvd_q;
	logic [SLOT_W-1:0]    rem_q;
	logic [CAP_W-1:0]     dsr_q;
	logic [SLOT_W-1:0]    rem_nxt;

	always_comb begin
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] d;
		logic [SLOT_W-1:0] r;
		d = REM_W'(dsr_q);
		r = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r, dvd_q[KEY_W-1-i]};
			if (t >= d) begin
				t = t - d;
			end
			r = t[SLOT_W-1:0];
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << DIV_BITS;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

>>> hw/rtl/linear_probe_hash_table_core.sv
// Channel  Direction  Payload (lowest bit up)               Transaction when
// s_axis   in         tdata: key[31:0] value[47:32]          s_axis_tvalid & s_axis_tready
//                     tuser: mode[1:0]
// m_axis   out        tdata: value_out[15:0]                 m_axis_tvalid & m_axis_tready
//                     tuser: status[1:0]
// cfg      in         data: table_capacity[8:0]             cfg_valid & cfg_ready
//
// Sequence: one item at a time. Insert and lookup go through accept, the home
//   slot remainder (4 key bits a cycle, then a hand-over), the probes and the
//   result. Clear, a reserved-key insert, zero capacity and mode 3 go straight
//   from accept to the result.
// Reset: valid bits all clear, capacity 256; RAMs are not cleared, an entry
//   whose valid bit is low reads as empty.
// Stalls: the result register holds while m_axis_tready is low; the next
//   item is still taken and stalls only at its own result.
module linear_probe_hash_table_core
	import lpht_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data,      // table_capacity[8:0]
	// requests
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [47:0]          s_axis_tdata,  // key[31:0], value[47:32]
	input  logic [MODE_W-1:0]    s_axis_tuser,  // mode[1:0]
	// results
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [VAL_W-1:0]     m_axis_tdata,  // value_out[15:0]
	output logic [STAT_W-1:0]    m_axis_tuser   // status[1:0]
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_INS  = 5'b00100,
		S_LKP  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     cfg_q;
	logic [CAP_W-1:0]     cap;
	logic [TABLE_DEPTH-1:0] used_q;

	mode_t                mode_q;
	logic [KEY_W-1:0]     key_q;
	logic [VAL_W-1:0]     val_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [CAP_W-1:0]     probes_q;
	logic                 pend_s1;   // key RAM read in flight for previous slot

	status_t              res_stat_q;
	logic [VAL_W-1:0]     res_val_q;
	logic                 out_valid_q;
	status_t              out_stat_q;
	logic [VAL_W-1:0]     out_val_q;

	div_req_t             div_req;
	div_rsp_t             div_rsp;

	logic [KEY_W-1:0]     key_rd;
	logic [VAL_W-1:0]     val_rd;
	logic                 key_we;
	logic                 rd_en;
	logic [SLOT_W-1:0]    slot_nxt;
	logic [REM_W-1:0]     slot_inc;

	logic                 in_acc;
	mode_t                in_mode;
	logic [KEY_W-1:0]     in_key;
	logic [VAL_W-1:0]     in_val;
	logic                 out_free;
	logic                 out_load;
	logic                 hit;
	logic                 probes_done;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_mode       = mode_t'(s_axis_tuser);
	assign in_key        = s_axis_tdata[KEY_W-1:0];
	assign in_val        = s_axis_tdata[KEY_W +: VAL_W];
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = (state_q == S_DONE) && out_free;

	// capacity above the table depth acts as the depth
	assign cap = (32'(cfg_q) > 32'(TABLE_DEPTH)) ? CAP_W'(TABLE_DEPTH) : CAP_W'(cfg_q);

	// linear probe with wrap at capacity
	assign slot_inc = REM_W'(slot_q) + 1'b1;
	assign slot_nxt = (slot_inc >= REM_W'(cap)) ? '0 : slot_inc[SLOT_W-1:0];

	assign probes_done = (probes_q == cap);
	assign hit         = pend_s1 && (key_rd == key_q);

	assign key_we = (state_q == S_INS) && !probes_done && !used_q[slot_q];
	assign rd_en  = (state_q == S_LKP) && !hit && !probes_done && used_q[slot_q];

	assign div_req.start    = in_acc && (in_mode == MODE_INSERT || in_mode == MODE_LOOKUP)
	                          && !(in_mode == MODE_INSERT && in_key == EMPTY_KEY)
	                          && (cap != '0);
	assign div_req.dividend = in_key;
	assign div_req.divisor  = cap;

	lpht_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lpht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (slot_q),
		.wdata (key_q),
		.re    (rd_en),
		.raddr (slot_q),
		.rdata (key_rd)
	);

	lpht_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (slot_q),
		.wdata (val_q),
		.re    (rd_en),
		.raddr (slot_q),
		.rdata (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// control: state, valid bits, result register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one taken in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (div_req.start) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_DONE;
						end
						if (in_mode == MODE_CLEAR) begin
							used_q <= '0;
						end
					end
				end
				S_DIV: begin
					pend_s1 <= 1'b0;
					if (div_rsp.done) begin
						state_q <= (mode_q == MODE_INSERT) ? S_INS : S_LKP;
					end
				end
				S_INS: begin
					if (probes_done) begin
						state_q <= S_DONE;
					end else if (!used_q[slot_q]) begin
						used_q[slot_q] <= 1'b1;
						state_q        <= S_DONE;
					end
				end
				S_LKP: begin
					pend_s1 <= rd_en;
					if (hit || probes_done || !used_q[slot_q]) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					mode_q    <= in_mode;
					key_q     <= in_key;
					val_q     <= in_val;
					res_val_q <= '0;
					if (in_mode == MODE_INSERT && in_key == EMPTY_KEY) begin
						res_stat_q <= ST_RESERVED;
					end else if (cap == '0 && in_mode == MODE_INSERT) begin
						res_stat_q <= ST_FULL;
					end else if (cap == '0 && in_mode == MODE_LOOKUP) begin
						res_stat_q <= ST_MISS;
					end else begin
						res_stat_q <= ST_OK;
					end
				end
			end
			S_DIV: begin
				slot_q   <= div_rsp.rem;
				probes_q <= '0;
			end
			S_INS: begin
				if (probes_done) begin
					res_stat_q <= ST_FULL;
				end else if (!used_q[slot_q]) begin
					res_stat_q <= ST_OK;
				end else begin
					slot_q   <= slot_nxt;
					probes_q <= probes_q + 1'b1;
				end
			end
			S_LKP: begin
				// an earlier probe's compare wins over the current slot's state
				if (hit) begin
					res_stat_q <= ST_OK;
					res_val_q  <= val_rd;
				end else if (probes_done || !used_q[slot_q]) begin
					res_stat_q <= ST_MISS;
				end else begin
					slot_q   <= slot_nxt;
					probes_q <= probes_q + 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_stat_q <= res_stat_q;
					out_val_q  <= res_val_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = out_stat_q;

endmodule

>>> sim/tb_linear_probe_hash_table_core.sv
module tb_linear_probe_hash_table_core;
	import lpht_pkg::*;

	// cycles with no transaction on any channel before the run is abandoned;
	// the slowest item is a lookup miss over a full 256-slot table
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned ROUND_ITEMS    = 100;
	localparam int unsigned LIVE_KEYS_MAX  = 48;

	typedef struct packed {
		mode_t             op;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  val;
	} table_request_t;

	typedef struct packed {
		status_t           status;
		logic [VAL_W-1:0]  data;
	} table_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [47:0]        s_axis_tdata = '0;   // key[31:0], value[47:32]
	logic [MODE_W-1:0]  s_axis_tuser = '0;   // mode[1:0]
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [VAL_W-1:0]   m_axis_tdata;        // value_out[15:0]
	logic [STAT_W-1:0]  m_axis_tuser;        // status[1:0]

	// shadow of the table: keys, values, occupancy and the capacity register
	logic [KEY_W-1:0]   shadow_key [TABLE_DEPTH];
	logic [VAL_W-1:0]   shadow_val [TABLE_DEPTH];
	bit                 shadow_used [TABLE_DEPTH];
	logic [CFG_W-1:0]   shadow_capacity;

	table_request_t     request_queue [$];
	table_answer_t      expected_answers [$];
	table_request_t     next_req;
	table_answer_t      due;
	logic [KEY_W-1:0]   live_keys [$];        // keys recently inserted, for hits

	int unsigned        send_gap_pct = 8;     // sender idles this often
	int unsigned        stall_pct = 46;       // receiver stalls this often
	int unsigned        requests_queued = 0;
	int unsigned        answers_seen = 0;
	int unsigned        quiet_cycles = 0;
	int unsigned        error_count = 0;

	linear_probe_hash_table_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Applies one request to the shadow table and returns the answer due.
	// Capacity above the depth acts as the depth; probing wraps at capacity.
	function automatic table_answer_t table_apply(input mode_t op,
			input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val);
		table_answer_t ans;
		int unsigned   cap;
		int unsigned   slot;
		int unsigned   n;
		bit            done;
		ans.status = ST_OK;
		ans.data   = '0;
		done       = 1'b0;
		cap = (shadow_capacity > TABLE_DEPTH) ? TABLE_DEPTH : shadow_capacity;
		case (op)
			MODE_INSERT: begin
				if (key == EMPTY_KEY) begin
					ans.status = ST_RESERVED;
				end else begin
					ans.status = ST_FULL;
					if (cap != 0) begin
						slot = key % cap;
						for (n = 0; n < cap && !done; n++) begin
							if (!shadow_used[slot]) begin
								shadow_key[slot]  = key;
								shadow_val[slot]  = val;
								shadow_used[slot] = 1'b1;
								ans.status        = ST_OK;
								done              = 1'b1;
							end
							slot = (slot + 1 >= cap) ? 0 : slot + 1;
						end
					end
				end
			end
			MODE_LOOKUP: begin
				ans.status = ST_MISS;
				if (cap != 0) begin
					slot = key % cap;
					for (n = 0; n < cap && !done; n++) begin
						if (!shadow_used[slot]) begin
							done = 1'b1;
						end else if (shadow_key[slot] == key) begin
							ans.status = ST_OK;
							ans.data   = shadow_val[slot];
							done       = 1'b1;
						end
						slot = (slot + 1 >= cap) ? 0 : slot + 1;
					end
				end
			end
			MODE_CLEAR: begin
				for (n = 0; n < TABLE_DEPTH; n++) begin
					shadow_key[n]  = EMPTY_KEY;
					shadow_used[n] = 1'b0;
				end
			end
			default: begin
				// mode 3 does nothing and answers zero
			end
		endcase
		return ans;
	endfunction

	// A key whose home slot is the given one under capacity cap.
	function automatic logic [KEY_W-1:0] key_at_home(input int unsigned home,
			input int unsigned cap);
		longint unsigned span;
		if (cap == 0)
			return $urandom;
		span = (64'hFFFF_FFFE - home) / cap;
		return KEY_W'(home + longint'(cap) * $urandom_range(int'(span), 0));
	endfunction

	// Driver: presents queued requests; each accepted transaction is run
	// through the shadow table at once, so expectations follow accept order.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_answers.push_back(table_apply(mode_t'(s_axis_tuser),
					s_axis_tdata[31:0], s_axis_tdata[47:32]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_req = request_queue.pop_front();
					s_axis_tdata  <= {next_req.val, next_req.key};
					s_axis_tuser  <= next_req.op;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transaction against the oldest expectation.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				answers_seen++;
				if (expected_answers.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, got status %0d value %h",
						$time, m_axis_tuser, m_axis_tdata);
				end else begin
					due = expected_answers.pop_front();
					if (m_axis_tuser !== due.status) begin
						error_count++;
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, due.status, m_axis_tuser);
					end
					if (m_axis_tdata !== due.data) begin
						error_count++;
						$display("%0t: value_out mismatch, expected %h, got %h",
							$time, due.data, m_axis_tdata);
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: any transaction on any channel resets the count.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_request(input mode_t op, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val);
		request_queue.push_back('{op: op, key: key, val: val});
		requests_queued++;
	endtask

	// every request answered, plus a short settle
	task automatic wait_drained();
		while (answers_seen < requests_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// capacity is only rewritten with the core idle
	task automatic write_capacity(input logic [CFG_W-1:0] cap);
		wait_drained();
		@(posedge clk);
		cfg_data  <= cap;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_capacity = cap;
	endtask

	task automatic note_live_key(input logic [KEY_W-1:0] key);
		live_keys.push_back(key);
		if (live_keys.size() > LIVE_KEYS_MAX)
			void'(live_keys.pop_front());
	endtask

	// Mostly inserts and lookups on clustered and recently inserted keys, so
	// probe chains grow, wrap and fill; the rest is clears, mode 3,
	// reserved keys and fully random requests.
	task automatic random_round(input int unsigned n_items);
		int unsigned      ec;
		int unsigned      i;
		int unsigned      pick;
		int unsigned      home;
		logic [KEY_W-1:0] k;
		ec = (shadow_capacity > TABLE_DEPTH) ? TABLE_DEPTH : shadow_capacity;
		for (i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			home = (ec == 0) ? 0 : $urandom_range(ec - 1);
			if (pick < 42) begin
				case ($urandom_range(3))
					0: k = $urandom;
					1: k = key_at_home(home, ec);
					2: k = key_at_home(($urandom_range(1) != 0 && ec != 0) ? ec - 1 : 0, ec);
					default: k = (live_keys.size() != 0) ?
						live_keys[$urandom_range(live_keys.size() - 1)] : $urandom;
				endcase
				queue_request(MODE_INSERT, k, VAL_W'($urandom));
				note_live_key(k);
			end else if (pick < 82) begin
				if (live_keys.size() != 0 && $urandom_range(9) < 7)
					k = live_keys[$urandom_range(live_keys.size() - 1)];
				else if ($urandom_range(1) != 0)
					k = key_at_home(home, ec);
				else
					k = $urandom;
				queue_request(MODE_LOOKUP, k, VAL_W'($urandom));
			end else if (pick < 88) begin
				queue_request(($urandom_range(1) != 0) ? MODE_INSERT : MODE_LOOKUP,
					EMPTY_KEY, VAL_W'($urandom));
			end else if (pick < 91) begin
				queue_request(MODE_NOP, $urandom, VAL_W'($urandom));
			end else if (pick < 93) begin
				queue_request(MODE_CLEAR, $urandom, VAL_W'($urandom));
				live_keys.delete();
			end else begin
				k = ($urandom_range(3) == 0) ? EMPTY_KEY : $urandom;
				queue_request(mode_t'($urandom_range(3)), k, VAL_W'($urandom));
			end
		end
	endtask

	initial begin
		logic [CFG_W-1:0] round_caps [13];
		int unsigned      r;
		int unsigned      n;
		for (n = 0; n < TABLE_DEPTH; n++) begin
			shadow_key[n]  = EMPTY_KEY;
			shadow_val[n]  = '0;
			shadow_used[n] = 1'b0;
		end
		shadow_capacity = 9'd256;
		round_caps = '{9'd7, 9'd1, 9'd0, 9'd511, 9'd37, 9'd2, 9'd256, 9'd16,
			9'd300, 9'd255, 9'd5, 9'd0, 9'd256};
		round_caps[11] = CFG_W'($urandom_range(511, 1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset capacity of 256
		queue_request(MODE_LOOKUP, 32'h0, 16'h0);             // empty table
		queue_request(MODE_INSERT, 32'h0, 16'h0);
		queue_request(MODE_INSERT, 32'hFFFF_FFFE, 16'hFFFF);  // largest legal key
		queue_request(MODE_INSERT, EMPTY_KEY, 16'h1234);      // reserved key rejected
		queue_request(MODE_LOOKUP, EMPTY_KEY, 16'h0);         // reserved key never matches
		queue_request(MODE_LOOKUP, 32'hFFFF_FFFE, 16'h0);
		queue_request(MODE_INSERT, 32'd256, 16'h1234);        // collides with key 0
		queue_request(MODE_INSERT, 32'h0, 16'hABCD);          // duplicate key
		queue_request(MODE_LOOKUP, 32'h0, 16'h0);             // first match wins
		queue_request(MODE_LOOKUP, 32'd256, 16'h0);
		queue_request(MODE_INSERT, 32'd255, 16'h00FF);        // top slot
		queue_request(MODE_INSERT, 32'd511, 16'h8001);        // wraps past the top
		queue_request(MODE_LOOKUP, 32'd511, 16'h0);
		queue_request(MODE_LOOKUP, 32'd512, 16'h0);           // miss at first hole
		queue_request(MODE_NOP, 32'hAAAA_AAAA, 16'h5555);
		queue_request(MODE_INSERT, 32'hAAAA_AAAA, 16'h5555);
		queue_request(MODE_LOOKUP, 32'hAAAA_AAAA, 16'h0);
		queue_request(MODE_CLEAR, 32'h5555_5555, 16'hAAAA);
		queue_request(MODE_LOOKUP, 32'h0, 16'h0);             // gone after clear

		// two-slot table filled up
		write_capacity(9'd2);
		queue_request(MODE_INSERT, 32'd5, 16'd1);
		queue_request(MODE_INSERT, 32'd7, 16'd2);
		queue_request(MODE_INSERT, 32'd9, 16'd3);             // table full
		queue_request(MODE_LOOKUP, 32'd9, 16'h0);             // miss after capacity probes
		queue_request(MODE_LOOKUP, 32'd7, 16'h0);

		// random rounds; table contents carry across capacity changes
		for (r = 0; r < 13; r++) begin
			write_capacity(round_caps[r]);
			if (r == 5) begin
				send_gap_pct = 46;
				stall_pct    = 8;
			end else if (r == 9) begin
				send_gap_pct = 0;
				stall_pct    = 0;
			end
			random_round(ROUND_ITEMS);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_answers.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
